// ===== hw/rtl/erxc_pkg.sv =====
// Shared types, constants and verdict codes for the Ethernet receive classifier.
package erxc_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam logic [15:0] EtypeArp  = 16'h0806;
	localparam logic [15:0] EtypeIpv4 = 16'h0800;
	localparam logic [7:0]  ProtoTcp  = 8'd6;
	localparam logic [7:0]  ProtoUdp  = 8'd17;

	localparam logic [4:0] VerdictUdpOk      = 5'd0;
	localparam logic [4:0] VerdictArpOk      = 5'd1;
	localparam logic [4:0] VerdictEthShort   = 5'd2;
	localparam logic [4:0] VerdictEtype      = 5'd3;
	localparam logic [4:0] VerdictArpShort   = 5'd4;
	localparam logic [4:0] VerdictArpHw      = 5'd5;
	localparam logic [4:0] VerdictArpProto   = 5'd6;
	localparam logic [4:0] VerdictArpBody    = 5'd7;
	localparam logic [4:0] VerdictArpOp      = 5'd8;
	localparam logic [4:0] VerdictIpShort    = 5'd9;
	localparam logic [4:0] VerdictIpTotLen   = 5'd10;
	localparam logic [4:0] VerdictIpHdrLen   = 5'd11;
	localparam logic [4:0] VerdictIpVersion  = 5'd12;
	localparam logic [4:0] VerdictIpFrag     = 5'd13;
	localparam logic [4:0] VerdictIpDst      = 5'd14;
	localparam logic [4:0] VerdictIpCsum     = 5'd15;
	localparam logic [4:0] VerdictTcp        = 5'd16;
	localparam logic [4:0] VerdictProto      = 5'd17;
	localparam logic [4:0] VerdictUdpLen     = 5'd18;
	localparam logic [4:0] VerdictUdpCsum    = 5'd19;

	localparam logic [1:0] CfgLocalAddr  = 2'd0;
	localparam logic [1:0] CfgIpOffload  = 2'd1;
	localparam logic [1:0] CfgUdpOffload = 2'd2;

	typedef struct packed {
		logic [16:0] len;
		logic        ip_good;
		logic        udp_good;
		logic [63:0] eth_hdr;
		logic [47:0] eth_src;
		logic [63:0] hdr_word0;
		logic [7:0]  proto;
		logic [47:0] arp_mac0;
		logic [47:0] arp_mac1;
		logic [31:0] addr0;
		logic [31:0] addr1;
		logic [63:0] udp_hdr;
	} frame_t;

	typedef struct packed {
		logic [31:0] local_addr;
		logic        ip_offload;
		logic        udp_offload;
	} cfg_t;

endpackage

// ===== hw/rtl/erxc_front.sv =====
// Byte counter and header capture; hands a frame snapshot to the queue on the last byte.
module erxc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 last_byte,
	input  logic                 ip_checksum_good,
	input  logic                 udp_checksum_good,
	input  logic                 q_full,
	output logic                 push,
	output erxc_pkg::frame_t     push_data
);
	import erxc_pkg::*;

	logic [15:0] cnt_q;
	logic [63:0] eth_hdr_q, eth_hdr_d;
	logic [47:0] eth_src_q, eth_src_d;
	logic [63:0] word0_q, word0_d;
	logic [7:0]  proto_q, proto_d;
	logic [47:0] mac0_q, mac0_d;
	logic [47:0] mac1_q, mac1_d;
	logic [31:0] addr0_q, addr0_d;
	logic [31:0] addr1_q, addr1_d;
	logic [63:0] udp_q, udp_d;
	logic [3:0]  ihl;
	logic [15:0] ustart;
	logic        is_arp;
	logic        accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign is_arp   = (eth_hdr_q[15:0] == EtypeArp);
	assign ihl      = (cnt_q == 16'd14) ? data_byte[3:0] : word0_q[59:56];
	assign ustart   = 16'd14 + {10'd0, ihl, 2'b00};

	always_comb begin
		eth_hdr_d = eth_hdr_q;
		eth_src_d = eth_src_q;
		word0_d   = word0_q;
		proto_d   = proto_q;
		mac0_d    = mac0_q;
		mac1_d    = mac1_q;
		addr0_d   = addr0_q;
		addr1_d   = addr1_q;
		udp_d     = udp_q;
		for (int k = 0; k < 8; k++) begin
			if (cnt_q == ((k < 6) ? 16'(k) : 16'(k + 6)))
				eth_hdr_d[63 - 8 * k -: 8] = data_byte;
			if (cnt_q == 16'(14 + k))
				word0_d[63 - 8 * k -: 8] = data_byte;
			if (cnt_q >= 16'd14 && cnt_q == ustart + 16'(k))
				udp_d[63 - 8 * k -: 8] = data_byte;
		end
		for (int k = 0; k < 6; k++) begin
			if (cnt_q == 16'(6 + k))
				eth_src_d[47 - 8 * k -: 8] = data_byte;
			if (cnt_q == 16'(22 + k))
				mac0_d[47 - 8 * k -: 8] = data_byte;
			if (cnt_q == 16'(32 + k))
				mac1_d[47 - 8 * k -: 8] = data_byte;
		end
		for (int k = 0; k < 4; k++) begin
			if (cnt_q == (is_arp ? 16'(28 + k) : 16'(26 + k)))
				addr0_d[31 - 8 * k -: 8] = data_byte;
			if (cnt_q == (is_arp ? 16'(38 + k) : 16'(30 + k)))
				addr1_d[31 - 8 * k -: 8] = data_byte;
		end
		if (cnt_q == 16'd23)
			proto_d = data_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			eth_hdr_q <= '0;
			eth_src_q <= '0;
			word0_q   <= '0;
			proto_q   <= '0;
			mac0_q    <= '0;
			mac1_q    <= '0;
			addr0_q   <= '0;
			addr1_q   <= '0;
			udp_q     <= '0;
		end else if (accept) begin
			eth_hdr_q <= eth_hdr_d;
			eth_src_q <= eth_src_d;
			word0_q   <= word0_d;
			proto_q   <= proto_d;
			mac0_q    <= mac0_d;
			mac1_q    <= mac1_d;
			addr0_q   <= addr0_d;
			addr1_q   <= addr1_d;
			udp_q     <= udp_d;
			if (last_byte)
				cnt_q <= '0;
			else if (cnt_q != 16'hFFFF)
				cnt_q <= cnt_q + 16'd1;
		end
	end

	assign push = accept && last_byte;

	always_comb begin
		push_data.len       = {1'b0, cnt_q} + 17'd1;
		push_data.ip_good   = ip_checksum_good;
		push_data.udp_good  = udp_checksum_good;
		push_data.eth_hdr   = eth_hdr_d;
		push_data.eth_src   = eth_src_d;
		push_data.hdr_word0 = word0_d;
		push_data.proto     = proto_d;
		push_data.arp_mac0  = mac0_d;
		push_data.arp_mac1  = mac1_d;
		push_data.addr0     = addr0_d;
		push_data.addr1     = addr1_d;
		push_data.udp_hdr   = udp_d;
	end

endmodule

// ===== hw/rtl/erxc_queue.sv =====
// Small FIFO of frame snapshots between the capture front and the classifier back.
module erxc_queue #(
	parameter int unsigned DEPTH = erxc_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  erxc_pkg::frame_t push_data,
	input  logic             pop,
	output erxc_pkg::frame_t head,
	output logic             full,
	output logic             not_empty
);
	import erxc_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_t         mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== hw/rtl/erxc_back.sv =====
// Frame checks in priority order and the registered result stage.
module erxc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  erxc_pkg::cfg_t   cfg,
	input  erxc_pkg::frame_t head,
	input  logic             not_empty,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [4:0]       verdict,
	output logic [47:0]      dst_mac,
	output logic [47:0]      src_mac,
	output logic [15:0]      ethertype,
	output logic [31:0]      src_ip,
	output logic [31:0]      dst_ip,
	output logic [15:0]      net_type,
	output logic [15:0]      udp_src_port,
	output logic [15:0]      udp_dst_port,
	output logic [15:0]      payload_offset,
	output logic [15:0]      payload_length
);
	import erxc_pkg::*;

	logic [15:0] et;
	logic [16:0] rem;
	logic [63:0] a;
	logic [15:0] tot;
	logic [5:0]  hlen;
	logic [15:0] urem;
	logic [15:0] ulen;
	logic [15:0] frag;
	logic [4:0]  v;
	logic        out_valid_q;

	assign et   = head.eth_hdr[15:0];
	assign rem  = head.len - 17'd14;
	assign a    = head.hdr_word0;
	assign tot  = a[47:32];
	assign hlen = {a[59:56], 2'b00};
	assign urem = tot - {10'd0, hlen};
	assign ulen = head.udp_hdr[31:16];
	assign frag = a[15:0];

	always_comb begin
		if (head.len < 17'd14)
			v = VerdictEthShort;
		else if (et == EtypeArp) begin
			if (rem < 17'd8)
				v = VerdictArpShort;
			else if (a[63:48] != 16'd1 || a[31:24] != 8'd6)
				v = VerdictArpHw;
			else if (a[47:32] != EtypeIpv4 || a[23:16] != 8'd4)
				v = VerdictArpProto;
			else if (rem < 17'd28)
				v = VerdictArpBody;
			else if (a[15:0] != 16'd1 && a[15:0] != 16'd2)
				v = VerdictArpOp;
			else
				v = VerdictArpOk;
		end else if (et != EtypeIpv4)
			v = VerdictEtype;
		else if (rem < 17'd20)
			v = VerdictIpShort;
		else if ({1'b0, tot} != rem)
			v = VerdictIpTotLen;
		else if ({10'd0, hlen} > tot)
			v = VerdictIpHdrLen;
		else if (a[63:60] != 4'd4)
			v = VerdictIpVersion;
		else if (frag[13] || frag[12:0] != 13'd0)
			v = VerdictIpFrag;
		else if (head.addr1 != cfg.local_addr)
			v = VerdictIpDst;
		else if (!cfg.ip_offload || !head.ip_good)
			v = VerdictIpCsum;
		else if (head.proto == ProtoTcp)
			v = VerdictTcp;
		else if (head.proto != ProtoUdp)
			v = VerdictProto;
		else if (urem < 16'd8 || ulen != urem)
			v = VerdictUdpLen;
		else if (!cfg.udp_offload || !head.udp_good)
			v = VerdictUdpCsum;
		else
			v = VerdictUdpOk;
	end

	assign pop       = not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (!out_valid_q || !out_stall)
			out_valid_q <= not_empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict        <= v;
			dst_mac        <= '0;
			src_mac        <= '0;
			ethertype      <= '0;
			src_ip         <= '0;
			dst_ip         <= '0;
			net_type       <= '0;
			udp_src_port   <= '0;
			udp_dst_port   <= '0;
			payload_offset <= '0;
			payload_length <= '0;
			if (v == VerdictArpOk) begin
				dst_mac   <= head.arp_mac1;
				src_mac   <= head.arp_mac0;
				ethertype <= et;
				src_ip    <= head.addr0;
				dst_ip    <= head.addr1;
				net_type  <= a[15:0];
			end else if (v == VerdictUdpOk) begin
				dst_mac        <= head.eth_hdr[63:16];
				src_mac        <= head.eth_src;
				ethertype      <= et;
				src_ip         <= head.addr0;
				dst_ip         <= head.addr1;
				net_type       <= {8'd0, head.proto};
				udp_src_port   <= head.udp_hdr[63:48];
				udp_dst_port   <= head.udp_hdr[47:32];
				payload_offset <= 16'd22 + {10'd0, hlen};
				payload_length <= ulen - 16'd8;
			end
		end
	end

endmodule

// ===== hw/rtl/ethernet_ip_udp_arp_rx_classifier.sv =====
// Top level of the Ethernet/ARP/IPv4/UDP receive classifier.
// Frame bytes enter on the input channel (in_valid, in_stall), one transfer
// per byte starting at the destination MAC, with last_byte set on the final
// byte and the NIC checksum flags valid with it. One byte is taken per cycle
// while in_stall is low. Each frame gives exactly one result transfer on the
// output channel (out_valid, out_stall): a verdict plus the captured
// addresses, ports and payload position. Frame snapshots pass through a
// two-entry queue into the check stage and its registered result stage, so
// the next frame streams in while a result waits; in_stall rises only when
// the queue is full because the receiver has held out_stall.
// Configuration writes use cfg_valid and cfg_ready, which is always high;
// index 0 is the local IPv4 address, 1 and 2 the checksum offload enables.
// Reset clears the byte counter, the captured headers, the queue and the
// configuration. The byte counter saturates at 65535.
module ethernet_ip_udp_arp_rx_classifier #(
	parameter int unsigned QUEUE_DEPTH = erxc_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        ip_checksum_good,
	input  logic        udp_checksum_good,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  verdict,
	output logic [47:0] dst_mac,
	output logic [47:0] src_mac,
	output logic [15:0] ethertype,
	output logic [31:0] src_ip,
	output logic [31:0] dst_ip,
	output logic [15:0] net_type,
	output logic [15:0] udp_src_port,
	output logic [15:0] udp_dst_port,
	output logic [15:0] payload_offset,
	output logic [15:0] payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import erxc_pkg::*;

	cfg_t   cfg_q;
	frame_t push_data, head;
	logic   push, pop, q_full, q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= '0;
		else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CfgLocalAddr:  cfg_q.local_addr  <= cfg_data;
				CfgIpOffload:  cfg_q.ip_offload  <= cfg_data[0];
				CfgUdpOffload: cfg_q.udp_offload <= cfg_data[0];
				default: ;
			endcase
		end
	end

	erxc_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .data_byte, .last_byte,
		.ip_checksum_good, .udp_checksum_good,
		.q_full, .push, .push_data
	);

	erxc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data, .pop, .head,
		.full(q_full), .not_empty(q_not_empty)
	);

	erxc_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .head, .not_empty(q_not_empty), .pop,
		.out_valid, .out_stall, .verdict, .dst_mac, .src_mac, .ethertype,
		.src_ip, .dst_ip, .net_type, .udp_src_port, .udp_dst_port,
		.payload_offset, .payload_length
	);

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> verdict <= VerdictUdpCsum)
		else $error("verdict out of range");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict > VerdictArpOk |->
		dst_mac == '0 && src_ip == '0 && udp_src_port == '0 && payload_offset == '0)
		else $error("rejected frame carries fields");

	a_arp_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && verdict == VerdictArpOk |->
		ethertype == EtypeArp && payload_length == '0 && udp_dst_port == '0)
		else $error("ARP result inconsistent");

	a_pop_feeds_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped frame not presented");

endmodule

// ===== tb/sv/ethernet_ip_udp_arp_rx_classifier_test.sv =====
// Testbench for the Ethernet/ARP/IPv4/UDP receive classifier: frame stimulus, predictor, checks.
module ethernet_ip_udp_arp_rx_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;
	import erxc_pkg::*;

	typedef enum int {
		FK_UDP_OK, FK_ARP_OK, FK_IHL_SHORT, FK_RAW_SHORT, FK_ETYPE, FK_ARP_SHORT,
		FK_ARP_HW, FK_ARP_PROTO, FK_ARP_BODY, FK_ARP_OP, FK_IP_SHORT, FK_TOTLEN,
		FK_HDRLEN, FK_VERSION, FK_FRAG, FK_DST, FK_IPCSUM, FK_TCP, FK_PROTO,
		FK_UDPLEN, FK_UDPCSUM
	} frame_kind_e;

	typedef struct {
		frame_kind_e kind;
		int          arg;
		bit          typed;
		logic [4:0]  want;
	} frame_plan_t;

	typedef struct packed {
		logic [4:0]  verdict;
		logic [47:0] dst_mac;
		logic [47:0] src_mac;
		logic [15:0] ethertype;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] net_type;
		logic [15:0] udp_src_port;
		logic [15:0] udp_dst_port;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
	} verdict_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        ip_checksum_good = 1'b0;
	logic        udp_checksum_good = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [4:0]  verdict;
	logic [47:0] dst_mac, src_mac;
	logic [15:0] ethertype;
	logic [31:0] src_ip, dst_ip;
	logic [15:0] net_type, udp_src_port, udp_dst_port, payload_offset, payload_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CfgLocalAddr;
	logic [31:0] cfg_data = 32'd0;

	ethernet_ip_udp_arp_rx_classifier DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("FAIL");
		$finish;
	end

	// Predictor state and its copy of the configuration.
	logic [31:0] local_addr = 32'd0;
	logic        ip_offload = 1'b0;
	logic        udp_offload = 1'b0;
	logic [15:0] byte_index = 16'd0;
	logic [63:0] eth_hdr = '0;
	logic [47:0] eth_src = '0;
	logic [63:0] arp_fixed = '0;
	logic [47:0] arp_mac [2] = '{48'd0, 48'd0};
	logic [63:0] ip_word [2] = '{64'd0, 64'd0};
	logic [31:0] addr [2] = '{32'd0, 32'd0};
	logic [63:0] udp_hdr = '0;

	verdict_rec_t pending_verdicts [$];
	int mismatches = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int stall_tick = 0;

	function automatic void capture_byte(int idx, logic [7:0] b);
		logic [15:0] et;
		int ihl, ustart;
		et = eth_hdr[15:0];
		if (idx < 6) eth_hdr[63-8*idx -: 8] = b;
		else if (idx < 12) eth_src[47-8*(idx-6) -: 8] = b;
		else if (idx < 14) eth_hdr[63-8*(idx-6) -: 8] = b;
		if (idx >= 14 && idx < 22) begin
			arp_fixed[63-8*(idx-14) -: 8] = b;
			ip_word[0][63-8*(idx-14) -: 8] = b;
		end
		if (idx >= 22 && idx < 30) ip_word[1][63-8*(idx-22) -: 8] = b;
		if (idx >= 22 && idx < 28) arp_mac[0][47-8*(idx-22) -: 8] = b;
		if (idx >= 32 && idx < 38) arp_mac[1][47-8*(idx-32) -: 8] = b;
		if (et == EtypeArp) begin
			if (idx >= 28 && idx < 32) addr[0][31-8*(idx-28) -: 8] = b;
			else if (idx >= 38 && idx < 42) addr[1][31-8*(idx-38) -: 8] = b;
		end else begin
			if (idx >= 26 && idx < 30) addr[0][31-8*(idx-26) -: 8] = b;
			else if (idx >= 30 && idx < 34) addr[1][31-8*(idx-30) -: 8] = b;
		end
		if (idx >= 14) begin
			ihl = ip_word[0][59:56];
			ustart = 14 + 4 * ihl;
			if (idx >= ustart && idx < ustart + 8) udp_hdr[63-8*(idx-ustart) -: 8] = b;
		end
	endfunction

	function automatic verdict_rec_t classify_frame(int len, logic ig, logic ug);
		verdict_rec_t r;
		logic [15:0] et, op, tot, frag, ulen;
		logic [7:0] proto;
		int rem, hlen, urem;
		r = '0;
		et = eth_hdr[15:0];
		if (len < 14) begin r.verdict = VerdictEthShort; return r; end
		rem = len - 14;
		if (et == EtypeArp) begin
			if (rem < 8) r.verdict = VerdictArpShort;
			else if (arp_fixed[63:48] != 16'd1 || arp_fixed[31:24] != 8'd6)
				r.verdict = VerdictArpHw;
			else if (arp_fixed[47:32] != EtypeIpv4 || arp_fixed[23:16] != 8'd4)
				r.verdict = VerdictArpProto;
			else if (rem - 8 < 20) r.verdict = VerdictArpBody;
			else begin
				op = arp_fixed[15:0];
				if (op != 16'd1 && op != 16'd2) r.verdict = VerdictArpOp;
				else begin
					r.verdict = VerdictArpOk;
					r.dst_mac = arp_mac[1];
					r.src_mac = arp_mac[0];
					r.ethertype = et;
					r.src_ip = addr[0];
					r.dst_ip = addr[1];
					r.net_type = op;
				end
			end
			return r;
		end
		if (et != EtypeIpv4) begin r.verdict = VerdictEtype; return r; end
		if (rem < 20) begin r.verdict = VerdictIpShort; return r; end
		tot = ip_word[0][47:32];
		if (int'(tot) != rem) begin r.verdict = VerdictIpTotLen; return r; end
		hlen = 4 * int'(ip_word[0][59:56]);
		frag = ip_word[0][15:0];
		proto = ip_word[1][55:48];
		ulen = udp_hdr[47:32] == 16'd0 ? udp_hdr[31:16] : udp_hdr[31:16];
		if (hlen > int'(tot)) r.verdict = VerdictIpHdrLen;
		else if (ip_word[0][63:60] != 4'd4) r.verdict = VerdictIpVersion;
		else if (frag[13] || frag[12:0] != 13'd0) r.verdict = VerdictIpFrag;
		else if (addr[1] != local_addr) r.verdict = VerdictIpDst;
		else if (!ip_offload || !ig) r.verdict = VerdictIpCsum;
		else if (proto == ProtoTcp) r.verdict = VerdictTcp;
		else if (proto != ProtoUdp) r.verdict = VerdictProto;
		else begin
			urem = int'(tot) - hlen;
			if (urem < 8 || int'(ulen) != urem) r.verdict = VerdictUdpLen;
			else if (!udp_offload || !ug) r.verdict = VerdictUdpCsum;
			else begin
				r.verdict = VerdictUdpOk;
				r.dst_mac = eth_hdr[63:16];
				r.src_mac = eth_src;
				r.ethertype = et;
				r.src_ip = addr[0];
				r.dst_ip = addr[1];
				r.net_type = {8'd0, proto};
				r.udp_src_port = udp_hdr[63:48];
				r.udp_dst_port = udp_hdr[47:32];
				r.payload_offset = 16'(14 + hlen + 8);
				r.payload_length = ulen - 16'd8;
			end
		end
		return r;
	endfunction

	function automatic void absorb_byte(logic [7:0] b, logic lst, logic ig, logic ug,
			bit typed, logic [4:0] want);
		verdict_rec_t r;
		int idx;
		idx = int'(byte_index);
		bytes_sent++;
		capture_byte(idx, b);
		if (!lst) begin
			if (byte_index != 16'hFFFF) byte_index++;
			return;
		end
		r = classify_frame(idx + 1, ig, ug);
		if (typed) begin
			r = '0;
			r.verdict = want;
		end
		pending_verdicts.push_back(r);
		byte_index = 16'd0;
	endfunction

	function automatic void build_frame(frame_kind_e kind, int arg, ref logic [7:0] q[$],
			ref logic ig, ref logic ug);
		int plen, ihl, hdr, tot, op;
		logic [15:0] e;
		q = {};
		ig = 1'b1;
		ug = 1'b1;
		for (int i = 0; i < 6; i++) q.push_back($urandom_range(0, 7) == 0 ? 8'hFF : 8'($urandom));
		for (int i = 0; i < 6; i++) q.push_back(8'($urandom));
		if (kind == FK_ARP_OK || kind == FK_ARP_SHORT || kind == FK_ARP_HW ||
				kind == FK_ARP_PROTO || kind == FK_ARP_BODY || kind == FK_ARP_OP) begin
			op = (kind == FK_ARP_OK) ? 1 + arg % 2 : ((arg % 2) ? 16'hFFFF : 3 + arg);
			q.push_back(EtypeArp[15:8]);
			q.push_back(EtypeArp[7:0]);
			q.push_back(8'h00); q.push_back(8'h01);
			q.push_back(EtypeIpv4[15:8]); q.push_back(EtypeIpv4[7:0]);
			q.push_back(8'd6); q.push_back(8'd4);
			q.push_back(8'(op >> 8)); q.push_back(8'(op));
			for (int i = 0; i < 20; i++) q.push_back(8'($urandom));
			for (int i = $urandom_range(0, 18); i > 0; i--) q.push_back(8'($urandom));
			case (kind)
				FK_ARP_SHORT: while (q.size() > 14 + arg % 8) void'(q.pop_back());
				FK_ARP_HW: if (arg % 2) q[18] = 8'd8; else q[15] = 8'd6;
				FK_ARP_PROTO: if (arg % 2) q[19] = 8'd16; else q[16] = 8'h86;
				FK_ARP_BODY: while (q.size() > 22 + arg % 20) void'(q.pop_back());
				default: ;
			endcase
			return;
		end
		plen = (kind == FK_UDP_OK) ? arg : $urandom_range(0, 20);
		ihl = (kind == FK_IHL_SHORT) ? arg % 5 : 5 + ($urandom_range(0, 3) == 0 ?
			$urandom_range(0, 2) : 0);
		hdr = (ihl >= 5) ? 4 * ihl : 20;
		tot = hdr + 8 + plen;
		q.push_back(EtypeIpv4[15:8]);
		q.push_back(EtypeIpv4[7:0]);
		q.push_back({4'd4, 4'(ihl)});
		q.push_back(8'($urandom));
		q.push_back(8'(tot >> 8)); q.push_back(8'(tot));
		q.push_back(8'($urandom)); q.push_back(8'($urandom));
		q.push_back($urandom_range(0, 1) ? 8'h40 : 8'h00); q.push_back(8'h00);
		q.push_back(8'($urandom));
		q.push_back(ProtoUdp);
		for (int i = 0; i < 6; i++) q.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) q.push_back(local_addr[31-8*i -: 8]);
		for (int i = 20; i < hdr; i++) q.push_back(8'($urandom));
		for (int i = 0; i < 4; i++) q.push_back(8'($urandom));
		q.push_back(8'((plen + 8) >> 8)); q.push_back(8'(plen + 8));
		q.push_back(8'($urandom)); q.push_back(8'($urandom));
		for (int i = 0; i < plen; i++) q.push_back(8'($urandom));
		case (kind)
			FK_RAW_SHORT: while (q.size() > 1 + arg % 13) void'(q.pop_back());
			FK_ETYPE: begin
				e = (arg % 2) ? 16'hFFFF : 16'($urandom);
				if (e == EtypeIpv4 || e == EtypeArp) e = 16'h0000;
				q[12] = e[15:8];
				q[13] = e[7:0];
			end
			FK_IP_SHORT: while (q.size() > 14 + arg % 20) void'(q.pop_back());
			FK_TOTLEN: for (int i = 0; i <= arg % 8; i++) q.push_back(8'($urandom));
			FK_HDRLEN: q[14][3:0] = 4'd15;
			FK_VERSION: q[14][7:4] = (arg % 16 == 4) ? 4'd5 : 4'(arg);
			FK_FRAG: if (arg % 2) q[21] = 8'(arg); else q[20] = q[20] | 8'h20;
			FK_DST: q[30 + arg % 4] ^= 8'(1 << (arg % 8));
			FK_IPCSUM: ig = 1'b0;
			FK_TCP: q[23] = ProtoTcp;
			FK_PROTO: q[23] = 8'(arg * 8);
			FK_UDPLEN: q[14 + hdr + 5] ^= 8'h01;
			FK_UDPCSUM: ug = 1'b0;
			default: ;
		endcase
	endfunction

	task automatic offer_byte(logic [7:0] b, logic lst, logic ig, logic ug, bit typed,
			logic [4:0] want);
		int gap;
		logic st;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		ip_checksum_good <= lst ? ig : 1'($urandom);
		udp_checksum_good <= lst ? ug : 1'($urandom);
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
		absorb_byte(b, lst, lst ? ig : 1'b0, lst ? ug : 1'b0, typed, want);
	endtask

	task automatic send_frame(frame_plan_t p);
		logic [7:0] q[$];
		logic ig, ug;
		build_frame(p.kind, p.arg, q, ig, ug);
		steady = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < q.size(); i++)
			offer_byte(q[i], i == q.size() - 1, ig, ug, p.typed, p.want);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic rd;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do begin
			@(negedge clk);
			rd = cfg_ready;
			@(posedge clk);
		end while (!rd);
		case (idx)
			CfgLocalAddr: local_addr = val;
			CfgIpOffload: ip_offload = val[0];
			CfgUdpOffload: udp_offload = val[0];
			default: ;
		endcase
	endtask

	task automatic reconfigure(logic [31:0] la, logic ipo, logic udpo);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(CfgLocalAddr, la);
		write_reg(CfgIpOffload, {31'd0, ipo});
		write_reg(CfgUdpOffload, {31'd0, udpo});
		cfg_valid <= 1'b0;
		burst_left = 0;
	endtask

	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			case (stall_tick[8:7])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 3) == 0);
				2'd2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= (stall_tick[2:0] == 3'd0);
			endcase
		end
	end

	always @(negedge clk) begin
		verdict_rec_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{verdict, dst_mac, src_mac, ethertype, src_ip, dst_ip, net_type,
				udp_src_port, udp_dst_port, payload_offset, payload_length};
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transfer: verdict %0d", verdict);
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: v=%0d dmac=%h smac=%h et=%h sip=%h dip=%h",
							want.verdict, want.dst_mac, want.src_mac, want.ethertype,
							want.src_ip, want.dst_ip);
						$display("  nt=%h sp=%h dp=%h off=%0d len=%0d", want.net_type,
							want.udp_src_port, want.udp_dst_port, want.payload_offset,
							want.payload_length);
						$display("mismatch got: v=%0d dmac=%h smac=%h et=%h sip=%h dip=%h",
							got.verdict, got.dst_mac, got.src_mac, got.ethertype,
							got.src_ip, got.dst_ip);
						$display("  nt=%h sp=%h dp=%h off=%0d len=%0d", got.net_type,
							got.udp_src_port, got.udp_dst_port, got.payload_offset,
							got.payload_length);
					end
				end
			end
		end
	end

	frame_plan_t directed_plan [26] = '{
		'{FK_RAW_SHORT, 0, 1'b1, VerdictEthShort},
		'{FK_RAW_SHORT, 12, 1'b1, VerdictEthShort},
		'{FK_ETYPE, 1, 1'b1, VerdictEtype},
		'{FK_ARP_SHORT, 7, 1'b1, VerdictArpShort},
		'{FK_ARP_HW, 0, 1'b1, VerdictArpHw},
		'{FK_ARP_HW, 1, 1'b1, VerdictArpHw},
		'{FK_ARP_PROTO, 0, 1'b1, VerdictArpProto},
		'{FK_ARP_PROTO, 1, 1'b1, VerdictArpProto},
		'{FK_ARP_BODY, 19, 1'b1, VerdictArpBody},
		'{FK_ARP_OP, 0, 1'b1, VerdictArpOp},
		'{FK_ARP_OK, 0, 1'b0, VerdictArpOk},
		'{FK_ARP_OK, 1, 1'b0, VerdictArpOk},
		'{FK_IP_SHORT, 19, 1'b1, VerdictIpShort},
		'{FK_TOTLEN, 5, 1'b1, VerdictIpTotLen},
		'{FK_HDRLEN, 0, 1'b1, VerdictIpHdrLen},
		'{FK_VERSION, 15, 1'b1, VerdictIpVersion},
		'{FK_FRAG, 0, 1'b1, VerdictIpFrag},
		'{FK_FRAG, 255, 1'b1, VerdictIpFrag},
		'{FK_DST, 7, 1'b1, VerdictIpDst},
		'{FK_IPCSUM, 0, 1'b1, VerdictIpCsum},
		'{FK_TCP, 0, 1'b1, VerdictTcp},
		'{FK_PROTO, 31, 1'b1, VerdictProto},
		'{FK_UDPLEN, 0, 1'b1, VerdictUdpLen},
		'{FK_UDPCSUM, 0, 1'b1, VerdictUdpCsum},
		'{FK_UDP_OK, 0, 1'b0, VerdictUdpOk},
		'{FK_IHL_SHORT, 0, 1'b0, VerdictUdpOk}
	};

	initial begin
		frame_plan_t p;
		int phase, r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_frame(directed_plan[0]);
		reconfigure(32'($urandom), 1'b1, 1'b1);
		for (int i = 1; i < 26; i++) send_frame(directed_plan[i]);
		send_frame('{FK_IHL_SHORT, 4, 1'b0, VerdictUdpOk});
		phase = 0;
		do begin
			case (phase)
				0: reconfigure(32'hFFFF_FFFF, 1'b1, 1'b1);
				1: reconfigure(32'h0000_0000, 1'b0, 1'b0);
				2: reconfigure(32'($urandom), 1'b1, 1'b0);
				3: reconfigure(32'($urandom), 1'b0, 1'b1);
				default: reconfigure(32'($urandom), 1'($urandom_range(0, 3) != 0),
					1'($urandom_range(0, 3) != 0));
			endcase
			for (int f = 0; f < ((phase == 0) ? 6 : 3); f++) begin
				if (phase == 0 && f == 0) hold_req = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 68) p = '{FK_UDP_OK, $urandom_range(0, 31), 1'b0, VerdictUdpOk};
				else if (r < 80) p = '{FK_ARP_OK, $urandom_range(0, 31), 1'b0, VerdictArpOk};
				else p = '{frame_kind_e'($urandom_range(FK_IHL_SHORT, FK_UDPCSUM)),
					$urandom_range(0, 31), 1'b0, VerdictUdpOk};
				send_frame(p);
			end
			phase++;
		end while (bytes_sent < 1750);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
